/* hw/rtl/mrfb_pkg.sv */
// ----------------------------------------------------------------------------
// mrfb_pkg
// Shared types, constants and the crc step for the request frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package mrfb_pkg;

  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [7:0] FuncRead  = 8'h03;
  localparam logic [7:0] FuncWrite = 8'h06;
  localparam logic [7:0] RegAddrHi = 8'h07;
  localparam logic [7:0] RegAddrLo = 8'hD0;
  localparam logic [7:0] ZeroByte  = 8'h00;
  localparam logic [7:0] CountLo   = 8'h02;

  localparam logic OpRead  = 1'b0;
  localparam logic OpWrite = 1'b1;

  // byte positions within a frame
  localparam logic [2:0] PosAddr  = 3'd0;
  localparam logic [2:0] PosFunc  = 3'd1;
  localparam logic [2:0] PosB2    = 3'd2;
  localparam logic [2:0] PosB3    = 3'd3;
  localparam logic [2:0] PosB4    = 3'd4;
  localparam logic [2:0] PosB5    = 3'd5;
  localparam logic [2:0] PosCrcLo = 3'd6;
  localparam logic [2:0] PosCrcHi = 3'd7;

  typedef struct packed {
    logic       wr;   // address change request
    logic [7:0] dev;  // target device address
    logic [7:0] arg;  // last body byte
  } cmd_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/mrfb_front.sv */
// ----------------------------------------------------------------------------
// mrfb_front
// Input stage: takes commands and classifies them into queue entries.
// ----------------------------------------------------------------------------
`default_nettype none

module mrfb_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [15:0]   s_axis_tdata,  // device_id [7:0], new_id [15:8]
  input  wire logic          s_axis_tuser,  // operation
  output logic               cmd_valid_o,
  output mrfb_pkg::cmd_t     cmd_o,
  input  wire logic          cmd_ready_i
);

  logic           valid_q, valid_d;
  mrfb_pkg::cmd_t cmd_q;
  logic           take;

  assign s_axis_tready = !valid_q || cmd_ready_i;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // read requests carry the fixed count byte in the last body slot
  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q.wr  <= (s_axis_tuser == mrfb_pkg::OpWrite);
      cmd_q.dev <= s_axis_tdata[7:0];
      cmd_q.arg <= (s_axis_tuser == mrfb_pkg::OpWrite) ? s_axis_tdata[15:8]
                                                       : mrfb_pkg::CountLo;
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

`default_nettype wire

/* hw/rtl/mrfb_fifo.sv */
// ----------------------------------------------------------------------------
// mrfb_fifo
// Short command queue between the front and back stages.
// ----------------------------------------------------------------------------
`default_nettype none

module mrfb_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_valid_i,
  input  wire mrfb_pkg::cmd_t  push_cmd_i,
  output logic                 push_ready_o,
  output logic                 pop_valid_o,
  output mrfb_pkg::cmd_t       pop_cmd_o,
  input  wire logic            pop_ready_i
);

  mrfb_pkg::cmd_t                     mem_q [mrfb_pkg::FifoDepth];
  logic [mrfb_pkg::FifoPtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [mrfb_pkg::FifoPtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [mrfb_pkg::FifoCntW-1:0]      cnt_q, cnt_d;
  logic                               push, pop;

  assign push_ready_o = (cnt_q != mrfb_pkg::FifoCntW'(mrfb_pkg::FifoDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;

  function automatic logic [mrfb_pkg::FifoPtrW-1:0] ptr_inc(
    input logic [mrfb_pkg::FifoPtrW-1:0] p);
    if (p == mrfb_pkg::FifoPtrW'(mrfb_pkg::FifoDepth - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/mrfb_back.sv */
// ----------------------------------------------------------------------------
// mrfb_back
// Serializer: emits the eight frame bytes and folds the crc in per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mrfb_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cmd_valid_i,
  input  wire mrfb_pkg::cmd_t  cmd_i,
  output logic                 cmd_ready_o,
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  output logic [7:0]           m_axis_tdata,
  output logic                 m_axis_tlast
);

  logic           busy_q, busy_d;
  logic [2:0]     pos_q, pos_d;
  logic           ovalid_q, ovalid_d;
  logic [7:0]     odata_q;
  logic           olast_q;
  logic [15:0]    crc_q, crc_d;
  mrfb_pkg::cmd_t cmd_q;
  logic           adv, emit, load;
  logic [7:0]     byte_sel;

  assign adv  = !ovalid_q || m_axis_tready;
  assign emit = adv && busy_q;
  // next command is taken while the crc high byte goes out
  assign load = adv && cmd_valid_i && (!busy_q || pos_q == mrfb_pkg::PosCrcHi);
  assign cmd_ready_o = load;

  always_comb begin
    case (pos_q)
      mrfb_pkg::PosAddr:  byte_sel = cmd_q.dev;
      mrfb_pkg::PosFunc:  byte_sel = cmd_q.wr ? mrfb_pkg::FuncWrite : mrfb_pkg::FuncRead;
      mrfb_pkg::PosB2:    byte_sel = cmd_q.wr ? mrfb_pkg::RegAddrHi : mrfb_pkg::ZeroByte;
      mrfb_pkg::PosB3:    byte_sel = cmd_q.wr ? mrfb_pkg::RegAddrLo : mrfb_pkg::ZeroByte;
      mrfb_pkg::PosB4:    byte_sel = mrfb_pkg::ZeroByte;
      mrfb_pkg::PosB5:    byte_sel = cmd_q.arg;
      mrfb_pkg::PosCrcLo: byte_sel = crc_q[7:0];
      mrfb_pkg::PosCrcHi: byte_sel = crc_q[15:8];
      default:            byte_sel = mrfb_pkg::ZeroByte;
    endcase
  end

  always_comb begin
    busy_d   = busy_q;
    pos_d    = pos_q;
    ovalid_d = ovalid_q;
    crc_d    = crc_q;
    if (adv) begin
      ovalid_d = busy_q;
    end
    if (emit) begin
      pos_d = pos_q + 1'b1;
      if (pos_q == mrfb_pkg::PosCrcHi) begin
        busy_d = 1'b0;
      end
      if (pos_q < mrfb_pkg::PosCrcLo) begin
        crc_d = mrfb_pkg::crc_byte(crc_q, byte_sel);
      end
    end
    if (load) begin
      busy_d = 1'b1;
      pos_d  = mrfb_pkg::PosAddr;
      crc_d  = mrfb_pkg::CrcInit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      pos_q    <= mrfb_pkg::PosAddr;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      pos_q    <= pos_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
    if (load) begin
      cmd_q <= cmd_i;
    end
    if (emit) begin
      odata_q <= byte_sel;
      olast_q <= (pos_q == mrfb_pkg::PosCrcHi);
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tlast  = olast_q;

endmodule

`default_nettype wire

/* hw/rtl/modbus_request_frame_builder.sv */
// ----------------------------------------------------------------------------
// modbus_request_frame_builder
// Turns request commands into 8-byte rtu request frames, one byte per word.
// ----------------------------------------------------------------------------
// usage
// - s_axis carries one command per word: tuser is the operation (0 = read the
//   two measurement registers, 1 = change the device address), tdata holds
//   device_id in [7:0] and new_id in [15:8]
// - m_axis carries the frame in wire order, one byte per word: address, five
//   body bytes, crc low byte, crc high byte; tlast marks the crc high byte
// - the byte serializer gives one output byte per cycle while tready is high;
//   the next command is picked up while the crc high byte is loaded, so
//   frames follow each other with no gap
// - a taken command reaches m_axis through the input register, the queue,
//   the serializer load and the output register
// - the front register and a 2-entry queue hold up to three commands while
//   a frame is going out, so commands keep being taken
// - when the receiver drops tready the output word holds and the serializer
//   stops; the front keeps filling until the queue is full
// - reset clears all valid flags and the byte position; nothing is in flight
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_request_frame_builder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // device_id [7:0], new_id [15:8]
  input  wire logic        s_axis_tuser,   // operation
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // tx_byte [7:0]
  output logic             m_axis_tlast    // last_byte
);

  // front to queue
  logic           f_valid, f_ready;
  mrfb_pkg::cmd_t f_cmd;
  // queue to serializer
  logic           q_valid, q_ready;
  mrfb_pkg::cmd_t q_cmd;

  // takes and classifies commands
  mrfb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .cmd_valid_o  (f_valid),
    .cmd_o        (f_cmd),
    .cmd_ready_i  (f_ready)
  );

  // decouples the two sides
  mrfb_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(f_valid),
    .push_cmd_i  (f_cmd),
    .push_ready_o(f_ready),
    .pop_valid_o (q_valid),
    .pop_cmd_o   (q_cmd),
    .pop_ready_i (q_ready)
  );

  // builds the frame bytes and the crc on the fly
  mrfb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (q_valid),
    .cmd_i        (q_cmd),
    .cmd_ready_o  (q_ready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

`default_nettype wire

/* hw/rtl/mrfb_checker.sv */
// ----------------------------------------------------------------------------
// mrfb_checker
// Port-level checks on frame framing and ordering for the frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

module mrfb_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [7:0]  m_axis_tdata,
  input wire logic        m_axis_tlast
);

  logic       in_acc, out_acc;
  logic [2:0] byte_cnt_q;
  logic [2:0] pend_q;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q <= 3'd0;
      pend_q     <= 3'd0;
    end else begin
      if (out_acc) begin
        byte_cnt_q <= byte_cnt_q + 1'b1;
      end
      pend_q <= pend_q + {2'b00, in_acc} - {2'b00, out_acc && m_axis_tlast};
    end
  end

  // stalled output word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // tlast exactly on the eighth byte of a frame
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (m_axis_tlast == (byte_cnt_q == 3'd7)))
    else $error("tlast not on eighth byte");

  // no byte without an outstanding command
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (pend_q != 3'd0))
    else $error("frame byte without a command");

  // at most five commands in flight: front, two queue slots, serializer and
  // the frame whose crc high byte still waits in the output register
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 3'd5 |-> !s_axis_tready)
    else $error("command taken beyond internal capacity");

endmodule

bind modbus_request_frame_builder mrfb_checker u_mrfb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);

`default_nettype wire
